// ===== hw/rtl/qtl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtl_pkg - shared types and constants of the quadtree tile locator
// Widths, register indexes, quadrant codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package qtl_pkg;

	localparam int COORD_W    = 32;
	localparam int WIDE_W     = 36;
	localparam int PCT_W      = 7;
	localparam int PROD_W     = 39;
	localparam int DIGIT_W    = 16;
	localparam int REM_W      = 7;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_W      = DIGIT_W * DIV_STEPS;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int QUO_W      = 34;
	localparam int RECIP_SH   = 30;
	localparam logic [23:0] RECIP_100 = 24'd10737419;
	localparam int MAX_DEPTH  = 16;
	localparam int DEPTH_W    = 6;
	localparam int LIMIT_W    = 5;
	localparam int PATH_W     = 32;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WORLD_LO_X  = 3'd0,
		REG_WORLD_LO_Y  = 3'd1,
		REG_WORLD_HI_X  = 3'd2,
		REG_WORLD_HI_Y  = 3'd3,
		REG_OVERLAP_PCT = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_A = 2'd0,
		QUAD_B = 2'd1,
		QUAD_C = 2'd2,
		QUAD_D = 2'd3
	} quad_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_TEST,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic sum;
		logic test;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic at_limit;
		logic last_level;
		logic hit;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/quadtree_tile_locator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadtree_tile_locator - quadtree tile addressing with overlapping children
// Clamps an item rectangle to the world box and descends the quadtree,
// returning the path code, the depth reached and the final tile box.
// ----------------------------------------------------------------------------
// An accepted item is worked through L levels, where L is the number of
// levels tested (at most the saturated depth limit, 16): each level steps
// through the overlap multiply, the digit steps of the radix-65536 divide
// by 100, the child bounds and the quadrant test. One item is in work at a
// time, so the next item is taken only after the result is loaded; the
// result register lets the next item enter while the previous result waits.
// Configuration writes are taken every cycle.
module quadtree_tile_locator #(
	parameter int MAX_DEPTH = qtl_pkg::MAX_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [qtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [qtl_pkg::COORD_W-1:0]        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_lo_x,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_lo_y,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_hi_x,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_hi_y,
	input  wire logic [qtl_pkg::LIMIT_W-1:0]        depth_limit,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [qtl_pkg::PATH_W-1:0]              path_code,
	output logic [qtl_pkg::LIMIT_W-1:0]             depth_reached,
	output logic signed [qtl_pkg::COORD_W-1:0]      tile_lo_x,
	output logic signed [qtl_pkg::COORD_W-1:0]      tile_lo_y,
	output logic signed [qtl_pkg::COORD_W-1:0]      tile_hi_x,
	output logic signed [qtl_pkg::COORD_W-1:0]      tile_hi_y
);
	import qtl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	qtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	qtl_datapath #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rect_lo_x     (rect_lo_x),
		.rect_lo_y     (rect_lo_y),
		.rect_hi_x     (rect_hi_x),
		.rect_hi_y     (rect_hi_y),
		.depth_limit   (depth_limit),
		.cmd           (cmd),
		.sts           (sts),
		.path_code     (path_code),
		.depth_reached (depth_reached),
		.tile_lo_x     (tile_lo_x),
		.tile_lo_y     (tile_lo_y),
		.tile_hi_x     (tile_hi_x),
		.tile_hi_y     (tile_hi_y)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/qtl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtl_ctrl - sequencer of the quadtree tile locator
// Steps each level through multiply, digit division, bound sums and the
// quadrant test; owns the input and output handshakes.
// ----------------------------------------------------------------------------
module qtl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire qtl_pkg::sts_t sts,
	output qtl_pkg::cmd_t      cmd
);
	import qtl_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				state_d = sts.at_limit ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				cmd.test = 1'b1;
				state_d  = (sts.hit && !sts.last_level) ? ST_MUL : ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/qtl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtl_datapath - arithmetic and storage of the quadtree tile locator
// Configuration registers, clamped rectangle, current tile box, overlap
// multiply and radix-65536 divide by 100, quadrant test and result register.
// ----------------------------------------------------------------------------
module qtl_datapath #(
	parameter int MAX_DEPTH = qtl_pkg::MAX_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [qtl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [qtl_pkg::COORD_W-1:0]       cfg_data,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_lo_x,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_lo_y,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_hi_x,
	input  wire logic signed [qtl_pkg::COORD_W-1:0] rect_hi_y,
	input  wire logic [qtl_pkg::LIMIT_W-1:0]       depth_limit,
	input  wire qtl_pkg::cmd_t                     cmd,
	output qtl_pkg::sts_t                          sts,
	output logic [qtl_pkg::PATH_W-1:0]             path_code,
	output logic [qtl_pkg::LIMIT_W-1:0]            depth_reached,
	output logic signed [qtl_pkg::COORD_W-1:0]     tile_lo_x,
	output logic signed [qtl_pkg::COORD_W-1:0]     tile_lo_y,
	output logic signed [qtl_pkg::COORD_W-1:0]     tile_hi_x,
	output logic signed [qtl_pkg::COORD_W-1:0]     tile_hi_y
);
	import qtl_pkg::*;

	function automatic logic signed [COORD_W-1:0] clamp(
		input logic signed [COORD_W-1:0] v,
		input logic signed [COORD_W-1:0] lo,
		input logic signed [COORD_W-1:0] hi
	);
		logic signed [COORD_W-1:0] t;
		t = (v < lo) ? lo : v;
		return (t > hi) ? hi : t;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
		logic fits;
		fits = (&v[WIDE_W-1:COORD_W-1]) | ~(|v[WIDE_W-1:COORD_W-1]);
		if (fits) begin
			return v[COORD_W-1:0];
		end
		return v[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	// one quotient digit and the new remainder of {rem, dig} / 100
	function automatic logic [DIGIT_W+REM_W-1:0] div_digit(
		input logic [REM_W-1:0]   rem,
		input logic [DIGIT_W-1:0] dig
	);
		logic [DIGIT_W+REM_W-1:0]    t;
		logic [DIGIT_W+REM_W+23:0]   p;
		logic [DIGIT_W-1:0]          qd;
		logic [DIGIT_W+REM_W-1:0]    qe;
		logic [DIGIT_W+REM_W-1:0]    r;
		t  = {rem, dig};
		p  = {24'b0, t} * {{(DIGIT_W+REM_W){1'b0}}, RECIP_100};
		qd = p[RECIP_SH+DIGIT_W-1:RECIP_SH];
		qe = {{REM_W{1'b0}}, qd};
		r  = t - ((qe << 6) + (qe << 5) + (qe << 2));
		return {qd, r[REM_W-1:0]};
	endfunction

	function automatic logic signed [WIDE_W-1:0] wide(input logic signed [COORD_W-1:0] v);
		return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	// configuration
	logic signed [COORD_W-1:0] wlo_x_q, wlo_y_q, whi_x_q, whi_y_q;
	logic [PCT_W-1:0]          pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlo_x_q <= '0;
			wlo_y_q <= '0;
			whi_x_q <= '0;
			whi_y_q <= '0;
			pct_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WORLD_LO_X:  wlo_x_q <= cfg_data;
				REG_WORLD_LO_Y:  wlo_y_q <= cfg_data;
				REG_WORLD_HI_X:  whi_x_q <= cfg_data;
				REG_WORLD_HI_Y:  whi_y_q <= cfg_data;
				REG_OVERLAP_PCT: pct_q   <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// working registers
	logic signed [COORD_W-1:0] rx0_q, ry0_q, rx1_q, ry1_q;
	logic signed [COORD_W-1:0] bx0_q, by0_q, bx4_q, by4_q;
	logic [DEPTH_W-1:0]        lim_q, lvl_q;
	logic [PATH_W-1:0]         path_q;
	logic signed [COORD_W:0]   midx_q, midy_q;
	logic                      negx_q, negy_q;
	logic [DIV_W-1:0]          dvx_q, dvy_q, qux_q, quy_q;
	logic [REM_W-1:0]          rmx_q, rmy_q;
	logic signed [WIDE_W-1:0]  xa_q, xb_q, ya_q, yb_q;

	// midpoint and width
	logic signed [COORD_W:0] sumx, sumy, adjx, adjy, dx, dy, ndx, ndy;
	logic [COORD_W-1:0]      magx, magy;
	logic [PROD_W-1:0]       prodx, prody;
	logic [DEPTH_W-1:0]      lim_in;

	always_comb begin
		sumx  = {bx0_q[COORD_W-1], bx0_q} + {bx4_q[COORD_W-1], bx4_q};
		sumy  = {by0_q[COORD_W-1], by0_q} + {by4_q[COORD_W-1], by4_q};
		adjx  = sumx + $signed({{COORD_W{1'b0}}, sumx[COORD_W]});
		adjy  = sumy + $signed({{COORD_W{1'b0}}, sumy[COORD_W]});
		dx    = {bx4_q[COORD_W-1], bx4_q} - {bx0_q[COORD_W-1], bx0_q};
		dy    = {by4_q[COORD_W-1], by4_q} - {by0_q[COORD_W-1], by0_q};
		ndx   = -dx;
		ndy   = -dy;
		magx  = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
		magy  = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
		prodx = {{PCT_W{1'b0}}, magx} * {{COORD_W{1'b0}}, pct_q};
		prody = {{PCT_W{1'b0}}, magy} * {{COORD_W{1'b0}}, pct_q};
		lim_in = (DEPTH_W'(depth_limit) > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
		                                                       : DEPTH_W'(depth_limit);
	end

	// division digits
	logic [DIGIT_W+REM_W-1:0] stx, sty;
	assign stx = div_digit(rmx_q, dvx_q[DIV_W-1 -: DIGIT_W]);
	assign sty = div_digit(rmy_q, dvy_q[DIV_W-1 -: DIGIT_W]);

	// signed overlaps
	logic signed [WIDE_W-1:0] ox, oy, mxe, mye;
	always_comb begin
		ox  = $signed({{(WIDE_W-QUO_W){1'b0}}, qux_q[QUO_W-1:0]});
		oy  = $signed({{(WIDE_W-QUO_W){1'b0}}, quy_q[QUO_W-1:0]});
		if (negx_q) ox = -ox;
		if (negy_q) oy = -oy;
		mxe = {{(WIDE_W-COORD_W-1){midx_q[COORD_W]}}, midx_q};
		mye = {{(WIDE_W-COORD_W-1){midy_q[COORD_W]}}, midy_q};
	end

	// quadrant test
	logic signed [WIDE_W-1:0] ex0, ey0, ex4, ey4, qx0, qy0, qx1, qy1;
	logic                     xl, xr, yl, yr;
	logic                     hit_d, hit_c, hit_b, hit_a;
	quad_t                    code;

	always_comb begin
		ex0 = wide(bx0_q);
		ey0 = wide(by0_q);
		ex4 = wide(bx4_q);
		ey4 = wide(by4_q);
		qx0 = wide(rx0_q);
		qy0 = wide(ry0_q);
		qx1 = wide(rx1_q);
		qy1 = wide(ry1_q);
		xl  = (qx0 >= ex0) && (qx0 <= xa_q) && (qx1 >= ex0) && (qx1 <= xa_q);
		xr  = (qx0 >= xb_q) && (qx0 <= ex4) && (qx1 >= xb_q) && (qx1 <= ex4);
		yl  = (qy0 >= ey0) && (qy0 <= ya_q) && (qy1 >= ey0) && (qy1 <= ya_q);
		yr  = (qy0 >= yb_q) && (qy0 <= ey4) && (qy1 >= yb_q) && (qy1 <= ey4);
		hit_d = xl && yl;
		hit_c = xr && yl;
		hit_b = xl && yr;
		hit_a = xr && yr;
		if (hit_d) begin
			code = QUAD_D;
		end else if (hit_c) begin
			code = QUAD_C;
		end else if (hit_b) begin
			code = QUAD_B;
		end else begin
			code = QUAD_A;
		end
	end

	assign sts.hit        = hit_d | hit_c | hit_b | hit_a;
	assign sts.at_limit   = (lvl_q == lim_q);
	assign sts.last_level = ((lvl_q + DEPTH_W'(1)) == lim_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rx0_q  <= clamp(rect_lo_x, wlo_x_q, whi_x_q);
			ry0_q  <= clamp(rect_lo_y, wlo_y_q, whi_y_q);
			rx1_q  <= clamp(rect_hi_x, wlo_x_q, whi_x_q);
			ry1_q  <= clamp(rect_hi_y, wlo_y_q, whi_y_q);
			bx0_q  <= wlo_x_q;
			by0_q  <= wlo_y_q;
			bx4_q  <= whi_x_q;
			by4_q  <= whi_y_q;
			lim_q  <= lim_in;
			lvl_q  <= '0;
			path_q <= '0;
		end
		if (cmd.mul) begin
			midx_q <= adjx >>> 1;
			midy_q <= adjy >>> 1;
			negx_q <= dx[COORD_W];
			negy_q <= dy[COORD_W];
			dvx_q  <= {{(DIV_W-PROD_W){1'b0}}, prodx};
			dvy_q  <= {{(DIV_W-PROD_W){1'b0}}, prody};
			rmx_q  <= '0;
			rmy_q  <= '0;
			qux_q  <= '0;
			quy_q  <= '0;
		end
		if (cmd.div_step) begin
			dvx_q <= dvx_q << DIGIT_W;
			dvy_q <= dvy_q << DIGIT_W;
			rmx_q <= stx[REM_W-1:0];
			rmy_q <= sty[REM_W-1:0];
			qux_q <= {qux_q[DIV_W-DIGIT_W-1:0], stx[DIGIT_W+REM_W-1:REM_W]};
			quy_q <= {quy_q[DIV_W-DIGIT_W-1:0], sty[DIGIT_W+REM_W-1:REM_W]};
		end
		if (cmd.sum) begin
			xa_q <= mxe + ox;
			xb_q <= mxe - ox;
			ya_q <= mye + oy;
			yb_q <= mye - oy;
		end
		if (cmd.test && sts.hit) begin
			case (code)
				QUAD_D: begin
					bx4_q <= sat(xa_q);
					by4_q <= sat(ya_q);
				end
				QUAD_C: begin
					bx0_q <= sat(xb_q);
					by4_q <= sat(ya_q);
				end
				QUAD_B: begin
					bx4_q <= sat(xa_q);
					by0_q <= sat(yb_q);
				end
				default: begin
					bx0_q <= sat(xb_q);
					by0_q <= sat(yb_q);
				end
			endcase
			if (lvl_q < DEPTH_W'(PATH_W / 2)) begin
				path_q[{lvl_q[DEPTH_W-3:0], 1'b0} +: 2] <= code;
			end
			lvl_q <= lvl_q + DEPTH_W'(1);
		end
		if (cmd.out_load) begin
			path_code     <= path_q;
			depth_reached <= lvl_q[LIMIT_W-1:0];
			tile_lo_x     <= bx0_q;
			tile_lo_y     <= by0_q;
			tile_hi_x     <= bx4_q;
			tile_hi_y     <= by4_q;
		end
	end

endmodule
`default_nettype wire
